[hw/rtl/mxk_pkg.sv]
// ============================================================================
// mxk_pkg
// Shared types, widths and helpers for the multiplicative XOR keystream block.
// ============================================================================
package mxk_pkg;

    localparam int POS_BITS   = 24;
    localparam int BYTE_W     = 8;
    localparam int S_TDATA_W  = ((BYTE_W + POS_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W  = BYTE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FACTOR = 2'd2;

    // one classified request, front to back
    typedef struct packed {
        logic                bypass;
        logic                restart;
        logic [BYTE_W-1:0]   cipher;
        logic [POS_BITS-1:0] steps;
    } t_op;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // product modulo 256
    function automatic logic [BYTE_W-1:0] mul8(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
        logic [2*BYTE_W-1:0] p;
        p = {{BYTE_W{1'b0}}, a} * {{BYTE_W{1'b0}}, b};
        return p[BYTE_W-1:0];
    endfunction

endpackage

[hw/rtl/mxk_front.sv]
// ============================================================================
// mxk_front
// Accepts requests, tracks the expected next position and works out whether
// the key restarts from the seed and how many positions it must advance.
// ============================================================================
module mxk_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mxk_pkg::S_TDATA_W-1:0] i_s_tdata,   // cipher_byte, byte_position
    input  mxk_pkg::t_q_stat              i_q_stat,
    output logic                          o_push,
    output mxk_pkg::t_op                  o_op
);

    logic [mxk_pkg::POS_BITS:0]    r_next_pos;
    logic [mxk_pkg::POS_BITS:0]    n_next_pos;
    logic [mxk_pkg::BYTE_W-1:0]    cipher;
    logic [mxk_pkg::POS_BITS-1:0]  pos;
    logic [mxk_pkg::POS_BITS:0]    pos_ext;
    logic [mxk_pkg::POS_BITS:0]    fwd_steps;
    logic                          restart;

    assign cipher  = i_s_tdata[mxk_pkg::BYTE_W-1:0];
    assign pos     = i_s_tdata[mxk_pkg::BYTE_W +: mxk_pkg::POS_BITS];
    assign pos_ext = {1'b0, pos};

    // a repeated or earlier position rebuilds the key from the seed
    assign restart   = (r_next_pos == '0) || (pos_ext < r_next_pos);
    assign fwd_steps = pos_ext - r_next_pos + {{mxk_pkg::POS_BITS{1'b0}}, 1'b1};

    assign o_s_tready = !i_q_stat.full;
    assign o_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_op.bypass  = !i_enable;
        o_op.restart = restart;
        o_op.cipher  = cipher;
        o_op.steps   = restart ? pos : fwd_steps[mxk_pkg::POS_BITS-1:0];
    end

    always_comb begin
        n_next_pos = r_next_pos;
        if (o_push && i_enable) begin
            n_next_pos = pos_ext + {{mxk_pkg::POS_BITS{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_pos <= '0;
        end else begin
            r_next_pos <= n_next_pos;
        end
    end

endmodule

[hw/rtl/mxk_queue.sv]
// ============================================================================
// mxk_queue
// Two-entry queue of classified requests between front and back.
// ============================================================================
module mxk_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mxk_pkg::t_op     i_op,
    input  logic             i_pop,
    output mxk_pkg::t_op     o_op,
    output mxk_pkg::t_q_stat o_stat
);

    mxk_pkg::t_op r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic [1:0]   n_count;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_op         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

[hw/rtl/mxk_back.sv]
// ============================================================================
// mxk_back
// Advances the key by square-and-multiply over the step count, one exponent
// bit per cycle, then XORs the cipher byte and holds the result for output.
// ============================================================================
module mxk_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mxk_pkg::BYTE_W-1:0]    i_seed,
    input  logic [mxk_pkg::BYTE_W-1:0]    i_step_factor,
    input  mxk_pkg::t_q_stat              i_q_stat,
    input  mxk_pkg::t_op                  i_op,
    output logic                          o_pop,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mxk_pkg::M_TDATA_W-1:0] o_m_tdata    // plain_byte
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                          r_state,   n_state;
    logic [mxk_pkg::BYTE_W-1:0]    r_key,     n_key;
    logic [mxk_pkg::BYTE_W-1:0]    r_acc,     n_acc;
    logic [mxk_pkg::BYTE_W-1:0]    r_base,    n_base;
    logic [mxk_pkg::POS_BITS-1:0]  r_exp,     n_exp;
    logic [mxk_pkg::BYTE_W-1:0]    r_cipher,  n_cipher;
    logic                          r_out_valid, n_out_valid;
    logic [mxk_pkg::M_TDATA_W-1:0] r_out_data,  n_out_data;
    logic                          out_free;
    logic [mxk_pkg::BYTE_W-1:0]    start_key;
    logic [mxk_pkg::BYTE_W-1:0]    start_prod;
    logic [mxk_pkg::BYTE_W-1:0]    run_prod;
    logic [mxk_pkg::BYTE_W-1:0]    run_sq;

    assign out_free   = !r_out_valid || i_m_tready;
    assign start_key  = i_op.restart ? i_seed : r_key;
    assign start_prod = mxk_pkg::mul8(start_key, i_step_factor);
    assign run_prod   = mxk_pkg::mul8(r_acc, r_base);
    assign run_sq     = mxk_pkg::mul8(r_base, r_base);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        n_cipher    = r_cipher;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_op.bypass) begin
                        if (out_free) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_data  = i_op.cipher;
                        end
                    end else begin
                        // first exponent bit handled while loading
                        o_pop    = 1'b1;
                        n_acc    = i_op.steps[0] ? start_prod : start_key;
                        n_base   = mxk_pkg::mul8(i_step_factor, i_step_factor);
                        n_exp    = i_op.steps >> 1;
                        n_cipher = i_op.cipher;
                        n_state  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (r_exp == '0) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = r_cipher ^ r_acc;
                        n_key       = r_acc;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    if (r_exp[0]) begin
                        n_acc = run_prod;
                    end
                    n_base = run_sq;
                    n_exp  = r_exp >> 1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_base     <= n_base;
        r_exp      <= n_exp;
        r_cipher   <= n_cipher;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key       <= n_key;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/multiplicative_xor_keystream_top.sv]
// ============================================================================
// multiplicative_xor_keystream_top
// Keystream decryptor for table bytes: key(p) = seed * step_factor^p mod 256.
// ============================================================================
//  channel   direction  handshake               payload
//  s         in         i_s_tvalid/o_s_tready   cipher_byte[7:0], byte_position[31:8]
//  m         out        o_m_tvalid/i_m_tready   plain_byte[7:0]
//  cfg       in         i_cfg_valid/o_cfg_ready register index, 8-bit data
//
//  A pass-through byte goes from the queue head straight into the output register.
//  A decrypted byte is loaded with its first exponent bit handled, then the
//  square-and-multiply loop consumes the remaining bits of the step count
//  before the result is XORed with the cipher byte into the output register.
//  The queue holds up to two requests, so input keeps flowing while the key loop
//  runs or the output stalls, until both entries are full. Reset is synchronous
//  and clears the stored position, the key and the configuration registers.
// ============================================================================
module multiplicative_xor_keystream_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [mxk_pkg::S_TDATA_W-1:0]    i_s_tdata,   // cipher_byte, byte_position
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [mxk_pkg::M_TDATA_W-1:0]    o_m_tdata,   // plain_byte
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mxk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mxk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                       r_enable;
    logic [mxk_pkg::BYTE_W-1:0] r_seed;
    logic [mxk_pkg::BYTE_W-1:0] r_step_factor;
    logic                       push;
    logic                       pop;
    mxk_pkg::t_op               push_op;
    mxk_pkg::t_op               head_op;
    mxk_pkg::t_q_stat           q_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_seed        <= '0;
            r_step_factor <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mxk_pkg::REG_ENABLE:      r_enable      <= i_cfg_data[0];
                mxk_pkg::REG_SEED:        r_seed        <= i_cfg_data[mxk_pkg::BYTE_W-1:0];
                mxk_pkg::REG_STEP_FACTOR: r_step_factor <= i_cfg_data[mxk_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mxk_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_enable   (r_enable),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_op       (push_op)
    );

    mxk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (q_stat)
    );

    mxk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed        (r_seed),
        .i_step_factor (r_step_factor),
        .i_q_stat      (q_stat),
        .i_op          (head_op),
        .o_pop         (pop),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

endmodule

[hw/rtl/mxk_checker.sv]
// ============================================================================
// mxk_checker
// Port-level checks for the keystream decryptor, bound to the top level.
// ============================================================================
module mxk_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mxk_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                           o_cfg_ready
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // reset empties the request queue
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind multiplicative_xor_keystream_top mxk_checker u_mxk_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for the multiplicative XOR keystream decryptor.
// Cipher bytes and their table offsets are streamed in, and a local key tracker
// predicts each plain byte. The monitor compares each output with the oldest
// prediction. Stimulus has a directed part: pass-through, sequential, repeated
// and backward offsets, long jumps, and register changes between bursts. Random
// offset runs follow, with random gaps and stalls on both sides, and a long
// output stall that backs up the input.
// ============================================================================
module tb_top;

    localparam int SETTLE_CYCLES = 30;   // margin beyond the longest key loop

    typedef logic [mxk_pkg::BYTE_W-1:0]   t_byte;
    typedef logic [mxk_pkg::POS_BITS-1:0] t_pos;

    localparam logic [mxk_pkg::POS_BITS:0] POS_ONE = {{mxk_pkg::POS_BITS{1'b0}}, 1'b1};

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [mxk_pkg::S_TDATA_W-1:0]  i_s_tdata   = '0;   // cipher_byte, byte_position
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [mxk_pkg::M_TDATA_W-1:0]  o_m_tdata;          // plain_byte
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [mxk_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mxk_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register shadows and key tracker
    logic                         cfg_enable   = 1'b0;
    t_byte                        cfg_seed     = '0;
    t_byte                        cfg_factor   = '0;
    logic [mxk_pkg::POS_BITS:0]   key_next_pos = '0;
    t_byte                        key_last     = '0;

    t_byte               expected_plain[$];
    t_byte               want_plain;
    int                  fail_count    = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  ready_hold    = 0;

    multiplicative_xor_keystream_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // base^e mod 256 by square and multiply
    function automatic t_byte key_power(input t_byte base,
                                        input logic [mxk_pkg::POS_BITS:0] e);
        t_byte acc;
        t_byte sq;
        acc = 8'd1;
        sq  = base;
        for (int i = 0; i <= mxk_pkg::POS_BITS; i++) begin
            if (e[i]) begin
                acc = acc * sq;
            end
            sq = sq * sq;
        end
        return acc;
    endfunction

    function automatic t_byte next_plain_byte(input t_byte cipher, input t_pos pos);
        logic [mxk_pkg::POS_BITS:0] steps;
        if (!cfg_enable) begin
            return cipher;
        end
        // repeated or backward offset rebuilds the key from the seed
        if ({1'b0, pos} < key_next_pos) begin
            key_next_pos = '0;
        end
        if (key_next_pos == '0) begin
            key_last = cfg_seed;
            steps    = {1'b0, pos};
        end else begin
            steps = {1'b0, pos} - key_next_pos + POS_ONE;
        end
        key_last     = key_last * key_power(cfg_factor, steps);
        key_next_pos = {1'b0, pos} + POS_ONE;
        return cipher ^ key_last;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_plain.size() == 0) begin
                note_failure($sformatf("unexpected plain byte %02h", o_m_tdata));
            end else begin
                want_plain = expected_plain.pop_front();
                if (o_m_tdata !== want_plain) begin
                    note_failure($sformatf("plain byte expected %02h got %02h",
                                           want_plain, o_m_tdata));
                end
            end
        end
    end

    task automatic send_req(input t_byte cipher, input t_pos pos);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pos, cipher};
        do @(posedge i_clk); while (!o_s_tready);
        expected_plain.push_back(next_plain_byte(cipher, pos));
    endtask

    // drop the request line and let the block drain completely
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (expected_plain.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mxk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mxk_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mxk_pkg::REG_ENABLE:      cfg_enable = val[0];
            mxk_pkg::REG_SEED:        cfg_seed   = val;
            mxk_pkg::REG_STEP_FACTOR: cfg_factor = val;
            default: ;
        endcase
    endtask

    // call only while the block is idle
    task automatic apply_setting(input logic en, input logic [7:0] seed_val,
                                 input logic [7:0] factor_val);
        write_reg(mxk_pkg::REG_ENABLE, {7'd0, en});
        write_reg(mxk_pkg::REG_SEED, seed_val);
        write_reg(mxk_pkg::REG_STEP_FACTOR, factor_val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_setting();
        logic [7:0] seed_val;
        logic [7:0] factor_val;
        logic       en;
        en = ($urandom_range(99) < 85);
        case ($urandom_range(3))
            0:       seed_val = 8'h00;
            1:       seed_val = 8'hFF;
            default: seed_val = t_byte'($urandom_range(255));
        endcase
        case ($urandom_range(4))
            0:       factor_val = 8'h00;
            1:       factor_val = 8'h01;
            2:       factor_val = 8'hFF;
            default: factor_val = t_byte'($urandom_range(255));
        endcase
        apply_setting(en, seed_val, factor_val);
    endtask

    // runs of consecutive offsets, joined by skips, repeats, restarts and jumps
    task automatic feed_sequences(input int n_items);
        int   sent;
        int   run_len;
        int   pick;
        t_pos pos;
        sent = 0;
        pos  = t_pos'($urandom);
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                pos = pos + t_pos'($urandom_range(0, 3));
            end else if (pick < 70) begin
                pos = pos - t_pos'($urandom_range(1, 9));
            end else if (pick < 80) begin
                pos = t_pos'($urandom_range(0, 15));
            end else if (pick < 92) begin
                pos = pos + t_pos'($urandom_range(16, 24'hFFFFFF));
            end else begin
                pos = t_pos'($urandom);
            end
            run_len = $urandom_range(1, 10);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                send_req(t_byte'($urandom_range(255)), pos);
                pos = pos + t_pos'(1);
                sent++;
            end
        end
    endtask

    task automatic test_passthrough_after_reset();
        send_req(8'h00, 24'h000000);
        send_req(8'hFF, 24'hFFFFFF);
        settle();
    endtask

    task automatic test_directed_keystream();
        apply_setting(1'b1, 8'hA5, 8'h03);
        send_req(8'h00, 24'd0);
        send_req(8'hFF, 24'd1);
        send_req(8'h5A, 24'd2);
        send_req(8'hC3, 24'd5);        // short skip
        send_req(8'h3C, 24'd5);        // same offset again
        send_req(8'h81, 24'd3);        // backward
        send_req(8'h7E, 24'hFFFFFF);   // longest jump
        send_req(8'h18, 24'd0);
        settle();
        // stored key survives a factor change
        apply_setting(1'b1, 8'hA5, 8'h80);
        send_req(8'h11, 24'd1);
        send_req(8'h22, 24'd2);
        settle();
        // new seed only shows after a restart
        apply_setting(1'b1, 8'h3C, 8'h80);
        send_req(8'h33, 24'd3);
        send_req(8'h44, 24'd0);
        settle();
        apply_setting(1'b1, 8'hFF, 8'h00);
        send_req(8'h55, 24'd0);
        send_req(8'h66, 24'd7);
        settle();
        // disabled bytes leave the tracker alone
        apply_setting(1'b0, 8'hFF, 8'h00);
        send_req(8'h77, 24'd4);
        settle();
        apply_setting(1'b1, 8'hFF, 8'h00);
        send_req(8'h88, 24'd5);
        settle();
        apply_setting(1'b1, 8'h00, 8'h07);
        send_req(8'h99, 24'd0);
        send_req(8'hAA, 24'd1);
        settle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int chunk = 0; chunk < 3; chunk++) begin
            settle();
            random_setting();
            feed_sequences(n_items / 3);
        end
        settle();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        apply_setting(1'b1, 8'h01, 8'hFF);
        ready_hold = 300;
        for (int k = 0; k < 24; k++) begin
            send_req(t_byte'($urandom_range(255)), t_pos'(100 + k));
        end
        // sender waits for the backlog to clear, then resumes the same run
        settle();
        for (int k = 24; k < 30; k++) begin
            send_req(t_byte'($urandom_range(255)), t_pos'(100 + k));
        end
        settle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough_after_reset();
        test_directed_keystream();
        test_random_traffic(34, 65, 135);
        test_random_traffic(65, 34, 135);
        test_output_stall();
        test_random_traffic(0, 0, 135);
        settle();
        if (fail_count == 0 && expected_plain.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
